@@ hw/rtl/hvw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvw_pkg: shared types for the Huber quality-control weight block
// Register indexes, fixed data widths and the payload structs.
// ----------------------------------------------------------------------------
package hvw_pkg;

    localparam int DataWidth = 32;
    localparam int WeightWidth = 17;
    localparam int RegIndexWidth = 2;

    typedef enum logic [RegIndexWidth-1:0] {
        REG_QC_ENABLE = 2'd0,
        REG_LEFT_THRESHOLD = 2'd1,
        REG_RIGHT_THRESHOLD = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [DataWidth-1:0] departure;
        logic [DataWidth-1:0] obs_sigma;
    } in_item_t;

    typedef struct packed {
        logic [WeightWidth-1:0] weight;
        logic [DataWidth-1:0] weighted_departure;
        logic invalid;
    } out_item_t;

endpackage

@@ hw/rtl/hvw_ratio_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvw_ratio_pipe: pipelined ratio, square root and weighting
// Work items travel with a valid bit and a stall. Each quotient or root stage
// makes one quotient or root bit; an item enters each cycle unless stalled.
// ----------------------------------------------------------------------------
module hvw_ratio_pipe #(
    parameter int DW = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_out_of_band,
    input  logic in_invalid,
    input  logic in_neg,
    input  logic [DW-1:0] in_xm,
    input  logic [DW-1:0] in_cm,
    output logic out_valid,
    input  logic out_ready,
    output hvw_pkg::out_item_t out_item
);
    import hvw_pkg::*;

    localparam int PW = 2 * DW + 2;
    localparam int QB = 32;
    localparam int SB = 16;
    localparam int NS = 3 + QB + SB + 2;

    typedef struct packed {
        logic valid;
        logic oob;
        logic inv;
        logic neg;
        logic [DW-1:0] xm;
        logic [DW-1:0] cm;
        logic [PW-1:0] num;
        logic [PW-1:0] den;
        logic [QB-1:0] q;
        logic [QB-1:0] rem;
        logic [SB:0] root;
        logic [WeightWidth-1:0] w;
        logic [DW+WeightWidth-1:0] prod;
    } stage_t;

    stage_t st_reg [NS];
    stage_t st_next [NS];
    logic adv;

    assign adv = !st_reg[NS-1].valid || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        logic [PW-1:0] nsh;
        logic [QB+1:0] trial;
        logic [QB+1:0] remsh;
        logic [DW+WeightWidth-1:0] rnd;
        logic [DW-1:0] mag;
        st_next[0] = '0;
        for (int i = 1; i < NS; i++)
        begin
            st_next[i] = st_reg[i-1];
        end
        st_next[0].valid = in_valid;
        st_next[0].oob = in_out_of_band;
        st_next[0].inv = in_invalid;
        st_next[0].neg = in_neg;
        st_next[0].xm = in_xm;
        st_next[0].cm = in_cm;
        // stage 1: products c*x and x*x
        st_next[1].num = PW'(st_reg[0].cm) * PW'(st_reg[0].xm);
        st_next[1].den = PW'(st_reg[0].xm) * PW'(st_reg[0].xm);
        st_next[1].q = QB'(st_reg[0].cm);
        // stage 2: form 2*c*x - c*c (q field cleared)
        st_next[2].num = (st_reg[1].num << 1)
            - PW'(st_reg[1].cm) * PW'(st_reg[1].cm);
        st_next[2].q = '0;
        // quotient stages
        for (int i = 0; i < QB; i++)
        begin
            nsh = st_reg[2+i].num << 1;
            st_next[3+i].q = st_reg[2+i].q << 1;
            if (nsh >= st_reg[2+i].den)
            begin
                st_next[3+i].num = nsh - st_reg[2+i].den;
                st_next[3+i].q[0] = 1'b1;
            end
            else
            begin
                st_next[3+i].num = nsh;
            end
        end
        // square root stages: q bits feed two at a time into the remainder
        for (int i = 0; i < SB; i++)
        begin
            remsh = {st_reg[2+QB+i].rem, st_reg[2+QB+i].q[QB-1:QB-2]};
            trial = {(QB+2-SB-1)'(0), st_reg[2+QB+i].root} << 2 | (QB+2)'(1);
            st_next[3+QB+i].q = st_reg[2+QB+i].q << 2;
            st_next[3+QB+i].root = st_reg[2+QB+i].root << 1;
            if (remsh >= trial)
            begin
                st_next[3+QB+i].rem = QB'(remsh - trial);
                st_next[3+QB+i].root[0] = 1'b1;
            end
            else
            begin
                st_next[3+QB+i].rem = QB'(remsh);
            end
        end
        // weight selection and product
        if (!st_reg[NS-3].oob)
            st_next[NS-2].w = WeightWidth'(65536);
        else if (st_reg[NS-3].inv)
            st_next[NS-2].w = '0;
        else
            st_next[NS-2].w = WeightWidth'(st_reg[NS-3].root);
        st_next[NS-1].prod = (DW+WeightWidth)'(st_reg[NS-2].xm)
            * (DW+WeightWidth)'(st_reg[NS-2].w);
        rnd = st_reg[NS-1].prod + (DW+WeightWidth)'(st_reg[NS-1].neg ? 65535 : 0);
        mag = DW'(rnd >> 16);
        out_item.weight = st_reg[NS-1].w;
        out_item.weighted_departure = DW'($signed(st_reg[NS-1].neg ? -mag : mag));
        out_item.invalid = st_reg[NS-1].inv;
    end

    assign out_valid = st_reg[NS-1].valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                st_reg[i].valid <= 1'b0;
        end
        else if (adv)
        begin
            for (int i = 0; i < NS; i++)
                st_reg[i] <= st_next[i];
        end
    end

endmodule

@@ hw/rtl/hvw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvw_front: band classification and operand preparation
// Registers the classified request into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hvw_front #(
    parameter int DW = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic qc_enable,
    input  logic signed [DW-1:0] left_threshold,
    input  logic [DW-2:0] right_threshold,
    input  logic in_valid,
    output logic in_ready,
    input  hvw_pkg::in_item_t in_item,
    output logic q_valid,
    input  logic q_ready,
    output logic q_oob,
    output logic q_inv,
    output logic q_neg,
    output logic [DW-1:0] q_xm,
    output logic [DW-1:0] q_cm
);
    import hvw_pkg::*;

    localparam int EW = 3 + 2 * DW;

    logic [EW-1:0] ent_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    logic [EW-1:0] ent_new;
    logic signed [DW:0] x, left, right;
    logic oob, below, push, pop;
    logic [DW:0] xm, cm;

    always_comb
    begin
        x = (DW+1)'($signed(in_item.departure[DW-1:0]));
        left = (left_threshold > 0) ? '0 : (DW+1)'(left_threshold);
        right = $signed({2'b00, right_threshold});
        below = x < left;
        oob = qc_enable && (below || x > right);
        xm = x[DW] ? -x : x;
        cm = below ? -left : right;
        ent_new = {oob, oob && (in_item.obs_sigma[DW-1:0] == '0), x[DW],
                   xm[DW-1:0], cm[DW-1:0]};
    end

    assign in_ready = cnt_reg != 2'd2;
    assign push = in_valid && in_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign pop = q_valid && q_ready;
    assign {q_oob, q_inv, q_neg, q_xm, q_cm} = ent_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= ent_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ hw/rtl/huber_varqc_weight.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huber_varqc_weight: Huber variational quality-control weight
// Streams departures and returns the square-root Huber weight per request.
// ----------------------------------------------------------------------------
// Usage: each input request carries one departure (signed Q16.16) and its
// observation sigma. Each result carries the weight (Q1.16, 65536 = 1.0),
// the departure times the weight and an invalid flag that is set when sigma
// is zero for a departure outside the band.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Throughput is one request per cycle unless the receiver stalls. A request
// passes the front queue, one pipe input register, two product stages, 32
// quotient stages (one bit of the Q0.32 ratio each), 16 root stages (one
// root bit each) and two stages for weight selection and the final product.
// Reset empties the queue and the pipe and loads the default thresholds
// of -2.0 and +2.0 with weighting off.
// When the receiver stalls the whole back pipe holds; the front queue
// takes requests until both its entries are full, then in_ready falls.
// ----------------------------------------------------------------------------
module huber_varqc_weight (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [hvw_pkg::DataWidth-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  hvw_pkg::in_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output hvw_pkg::out_item_t out_data
);
    import hvw_pkg::*;

    logic qc_enable_reg;
    logic signed [DataWidth-1:0] left_reg;
    logic [DataWidth-2:0] right_reg;
    logic qv, qr, qoob, qinv, qneg;
    logic [DataWidth-1:0] qxm, qcm;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_enable_reg <= 1'b0;
            left_reg <= DataWidth'(-131072);
            right_reg <= (DataWidth-1)'(131072);
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_QC_ENABLE: qc_enable_reg <= cfg_data[0];
                REG_LEFT_THRESHOLD: left_reg <= cfg_data;
                REG_RIGHT_THRESHOLD: right_reg <= cfg_data[DataWidth-2:0];
                default: ;
            endcase
        end
    end

    hvw_front #(.DW(DataWidth)) u_front (
        .clk(clk), .rst_n(rst_n),
        .qc_enable(qc_enable_reg), .left_threshold(left_reg),
        .right_threshold(right_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
        .q_valid(qv), .q_ready(qr), .q_oob(qoob), .q_inv(qinv), .q_neg(qneg),
        .q_xm(qxm), .q_cm(qcm)
    );

    hvw_ratio_pipe #(.DW(DataWidth)) u_pipe (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_out_of_band(qoob),
        .in_invalid(qinv), .in_neg(qneg), .in_xm(qxm), .in_cm(qcm),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
    );

endmodule
